/* hw/rtl/cdte_pkg.sv */
// Package: shared types, constants and calendar helpers for the date-to-epoch block.
`timescale 1ns / 1ps

package cdte_pkg;

  // Input beat: one already-split date and time.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [1:0]  meridiem;
  } cdte_in_t;

  // Result beat.
  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic        valid_res;
  } cdte_out_t;

  // Meridiem codes.
  typedef enum logic [1:0] {
    MER_NONE = 2'd0,
    MER_AM   = 2'd1,
    MER_PM   = 2'd2,
    MER_BAD  = 2'd3
  } mer_e;

  localparam int unsigned DaysW = 16;  // days since 1970 for years 2000..2099
  localparam int unsigned TodW  = 17;  // seconds of day, up to 86399

  // Front-to-back work item.
  typedef struct packed {
    logic             ok;
    logic [DaysW-1:0] days;
    logic [TodW-1:0]  tod;
  } cdte_item_t;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  localparam logic [13:0] YearMin      = 14'd2000;
  localparam logic [13:0] YearMax      = 14'd2099;
  localparam logic [DaysW-1:0] Days2000 = 16'd10957;  // 1970-01-01 to 2000-01-01
  localparam logic [16:0] SecsPerDay   = 17'd86400;

  // Length of a month, 1..12; leap selects February's 29 days.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m (non-leap).
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

/* hw/rtl/civil_datetime_to_epoch_top.sv */
// Top level: civil date and time to Unix epoch seconds.
`timescale 1ns / 1ps

// Converts one split date/time beat (years 2000..2099, 24-hour or AM/PM form)
// to seconds since 1970-01-01 UTC. A beat is taken on any clock edge where
// start is high and busy is low; one beat per cycle is sustained. Each beat
// yields exactly one result, shown on result_o for one cycle with strobe_o
// high; strobe_o rises once the beat has passed the queue write, the multiply
// stage and the output register, and the result is taken at the edge after.
// The receiver cannot stall the block; the back end drains the queue every
// cycle, so the four-entry queue between the check logic and the multiplier
// never holds more than one beat and busy stays low.
// A beat that fails any check (year range, month, day for the month with
// leap years, minute, second, hour for the clock form, unknown meridiem)
// returns epoch_seconds zero with valid_res low. There is no configuration
// and no state besides the pipeline.
module civil_datetime_to_epoch_top import cdte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  cdte_in_t  data_i,
  output cdte_out_t result_o,
  output logic      strobe_o
);

  cdte_item_t front_item, q_item;
  logic       q_empty, q_full, back_pop, accept;

  assign busy   = q_full;
  assign accept = start && !q_full;

  // Front end: all checks and the day/second-of-day arithmetic, feeding the queue.
  cdte_front u_front (
    .beat_i (data_i),
    .item_o (front_item)
  );

  // Decoupling queue.
  cdte_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (front_item),
    .pop_i   (back_pop),
    .item_o  (q_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back end: 86400 multiply then final add.
  cdte_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .avail_i  (!q_empty),
    .item_i   (q_item),
    .pop_o    (back_pop),
    .result_o (result_o),
    .strobe_o (strobe_o)
  );

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 strobe_o)
    else $error("result beat not delivered after accept");
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(accept, 3))
    else $error("result beat without an accepted input");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !result_o.valid_res) |-> (result_o.epoch_seconds == 32'd0))
    else $error("invalid result carries nonzero seconds");
`endif

endmodule

/* hw/rtl/cdte_front.sv */
// Front end: field checks, 12-hour conversion, day count and second-of-day.
`timescale 1ns / 1ps

module cdte_front import cdte_pkg::*; (
  input  cdte_in_t   beat_i,
  output cdte_item_t item_o
);

  logic       year_ok, month_ok, day_ok, ms_ok, hour_ok, leap;
  logic [6:0] yoff;
  logic [4:0] hour24;
  logic [DaysW-1:0] days;
  logic [TodW-1:0]  tod;
  logic [13:0] ydiff;

  always_comb begin
    year_ok  = (beat_i.year >= YearMin) && (beat_i.year <= YearMax);
    month_ok = (beat_i.month >= 4'd1) && (beat_i.month <= 4'd12);
    ydiff    = beat_i.year - YearMin;
    yoff     = ydiff[6:0];
    // 2000 is a leap year, so within 2000..2099 leap is a multiple of four.
    leap     = (yoff[1:0] == 2'd0);
    day_ok   = (beat_i.day >= 5'd1) && (beat_i.day <= month_len(beat_i.month, leap));
    ms_ok    = (beat_i.minute <= 6'd59) && (beat_i.second <= 6'd59);

    hour24 = beat_i.hour;
    unique case (beat_i.meridiem)
      MER_NONE: hour_ok = (beat_i.hour <= 5'd23);
      MER_AM: begin
        hour_ok = (beat_i.hour >= 5'd1) && (beat_i.hour <= 5'd12);
        if (beat_i.hour == 5'd12) begin
          hour24 = 5'd0;
        end
      end
      MER_PM: begin
        hour_ok = (beat_i.hour >= 5'd1) && (beat_i.hour <= 5'd12);
        if (beat_i.hour < 5'd12) begin
          hour24 = beat_i.hour + 5'd12;
        end
      end
      default: hour_ok = 1'b0;
    endcase

    // Leap days before this year: ceil(yoff / 4); plus Feb 29 if past February.
    days = Days2000
         + DaysW'(yoff) * DaysW'(365)
         + DaysW'((8'(yoff) + 8'd3) >> 2)
         + DaysW'(days_before_month(beat_i.month))
         + DaysW'(leap && (beat_i.month > 4'd2))
         + DaysW'(beat_i.day)
         - DaysW'(1);

    tod = TodW'(hour24) * TodW'(3600) + TodW'(beat_i.minute) * TodW'(60)
        + TodW'(beat_i.second);

    item_o.ok   = year_ok && month_ok && day_ok && ms_ok && hour_ok;
    item_o.days = days;
    item_o.tod  = tod;
  end

endmodule

/* hw/rtl/cdte_queue.sv */
// Short FIFO between front and back ends.
`timescale 1ns / 1ps

module cdte_queue import cdte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cdte_item_t item_i,
  input  logic       pop_i,
  output cdte_item_t item_o,
  output logic       empty_o,
  output logic       full_o
);

  cdte_item_t         mem_q [QDepth];
  logic [QAw-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCw-1:0]     count_q, count_d;
  logic               do_push, do_pop;

  assign empty_o = (count_q == QCw'(0));
  assign full_o  = (count_q == QCw'(QDepth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QAw'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QAw'(1) : rd_ptr_q;
    count_d  = count_q + QCw'(do_push) - QCw'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCw'(QDepth))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != QCw'(QDepth)) |-> (QAw'(wr_ptr_q - rd_ptr_q) == QAw'(count_q)))
    else $error("queue pointers disagree with count");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + QCw'(1)))
    else $error("queue count did not grow on push");
`endif

endmodule

/* hw/rtl/cdte_back.sv */
// Back end: day count times 86400 plus second-of-day, registered result beat.
`timescale 1ns / 1ps

module cdte_back import cdte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       avail_i,
  input  cdte_item_t item_i,
  output logic       pop_o,
  output cdte_out_t  result_o,
  output logic       strobe_o
);

  logic            s1_vld_q;
  logic            s1_ok_q;
  logic [31:0]     s1_prod_q, s1_prod_d;
  logic [TodW-1:0] s1_tod_q;
  logic            out_vld_q;
  cdte_out_t       out_q, out_d;

  // The back end never stalls: take a beat whenever one is queued.
  assign pop_o = avail_i;

  always_comb begin
    // At most 47482 days by 2099, so the product fits in 32 bits.
    s1_prod_d = 32'(item_i.days) * 32'(SecsPerDay);
    out_d.valid_res     = s1_ok_q;
    out_d.epoch_seconds = s1_ok_q ? (s1_prod_q + 32'(s1_tod_q)) : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= avail_i;
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (avail_i) begin
      s1_ok_q   <= item_i.ok;
      s1_prod_q <= s1_prod_d;
      s1_tod_q  <= item_i.tod;
    end
    if (s1_vld_q) begin
      out_q <= out_d;
    end
  end

  assign result_o = out_q;
  assign strobe_o = out_vld_q;

endmodule

/* bench/tb.sv */
// Testbench for civil_datetime_to_epoch_top: directed corners plus random date/time beats.
`timescale 1ns / 1ps

// Each accepted beat goes into a local calendar predictor. The expected
// epoch seconds and valid flag wait in a queue until the matching result
// strobe arrives. The block keeps no state and has no configuration
// registers, so the test phases only vary the traffic:
//   - directed corners: field extremes, leap days, the meridiem forms
//   - random bursts with no sender gaps
//   - sparse traffic with the sender idle most cycles
//   - mixed traffic with occasional gaps
//   - a hold-off that lets the pipeline empty before traffic resumes
// The receiver cannot stall the block, so only the sender side idles.
module tb;
  import cdte_pkg::*;

  localparam int unsigned WatchLimit = 3000;  // quiet cycles before giving up
  localparam int unsigned TailCycles = 8;     // settle time after the last result
  localparam int unsigned MaxPrints  = 20;    // mismatch lines printed before going quiet

  // One outstanding beat: the input that was sent and the result it should give.
  typedef struct {
    cdte_in_t  src;
    cdte_out_t want;
  } epoch_due_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  cdte_in_t  data_i;
  cdte_out_t result_o;
  logic      strobe_o;

  epoch_due_t  epoch_due[$];
  int unsigned sender_idle_pct;
  int unsigned beats_sent;
  int unsigned results_seen;
  int unsigned valid_seen;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  civil_datetime_to_epoch_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .data_i   (data_i),
    .result_o (result_o),
    .strobe_o (strobe_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Gregorian month length; months outside 1..12 never reach here.
  function automatic int unsigned greg_month_days(input int unsigned y, input int unsigned m);
    bit leap;
    leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    case (m)
      2:              return leap ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  // Field checks, 12-hour fold, then the days-from-civil count shifted to 1970.
  function automatic cdte_out_t predict_epoch(input cdte_in_t d);
    longint unsigned y, m, dd, h, mi, s;
    longint unsigned yy, era, yoe, mp, doy, doe, days, secs;
    bit ok;
    cdte_out_t r;
    y  = d.year;
    m  = d.month;
    dd = d.day;
    h  = d.hour;
    mi = d.minute;
    s  = d.second;
    ok = 1'b1;
    r  = '0;

    if (y < YearMin || y > YearMax || m < 1 || m > 12) ok = 1'b0;
    else if (dd < 1 || dd > greg_month_days(y, m)) ok = 1'b0;
    if (mi > 59 || s > 59) ok = 1'b0;

    case (mer_e'(d.meridiem))
      MER_BAD:  ok = 1'b0;
      MER_NONE: if (h > 23) ok = 1'b0;
      default: begin
        if (h < 1 || h > 12) ok = 1'b0;
        else if (mer_e'(d.meridiem) == MER_PM && h < 12) h = h + 12;
        else if (mer_e'(d.meridiem) == MER_AM && h == 12) h = 0;
      end
    endcase

    if (!ok) return r;

    // March-based year so the leap day falls at the end.
    yy   = (m <= 2) ? y - 1 : y;
    era  = yy / 400;
    yoe  = yy - era * 400;
    mp   = (m > 2) ? m - 3 : m + 9;
    doy  = (153 * mp + 2) / 5 + dd - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    secs = days * 86400 + h * 3600 + mi * 60 + s;
    r.epoch_seconds = secs[31:0];
    r.valid_res     = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Accept monitor, result checker and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxPrints) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Push happens before the pop in the same block, so a result strobed as its beat
  // is accepted would still find its expectation. All reads see pre-edge values.
  always @(posedge clk_i) begin
    epoch_due_t e;
    if (rst_ni) begin
      if (start && !busy) begin
        e.src  = data_i;
        e.want = predict_epoch(data_i);
        epoch_due.push_back(e);
      end
      if (strobe_o) begin
        results_seen++;
        if (result_o.valid_res) valid_seen++;
        if (epoch_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: secs=%0d valid=%0b",
                                    result_o.epoch_seconds, result_o.valid_res));
        end else begin
          e = epoch_due.pop_front();
          if (result_o.epoch_seconds !== e.want.epoch_seconds)
            report_mismatch($sformatf(
              "%0d-%0d-%0d %0d:%0d:%0d mer=%0d: secs got %0d want %0d",
              e.src.year, e.src.month, e.src.day, e.src.hour, e.src.minute,
              e.src.second, e.src.meridiem, result_o.epoch_seconds,
              e.want.epoch_seconds));
          if (result_o.valid_res !== e.want.valid_res)
            report_mismatch($sformatf(
              "%0d-%0d-%0d %0d:%0d:%0d mer=%0d: valid got %0b want %0b",
              e.src.year, e.src.month, e.src.day, e.src.hour, e.src.minute,
              e.src.second, e.src.meridiem, result_o.valid_res, e.want.valid_res));
        end
      end
    end
  end

  // Any accepted beat or result resets the count; a hung block ends the run.
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchLimit) begin
      $display("watchdog: %0d quiet cycles, %0d results outstanding",
               quiet_cycles, epoch_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic cdte_in_t pack_dt(input int unsigned y, input int unsigned mo,
                                       input int unsigned d, input int unsigned h,
                                       input int unsigned mi, input int unsigned s,
                                       input mer_e mer);
    cdte_in_t it;
    it.year     = y[13:0];
    it.month    = mo[3:0];
    it.day      = d[4:0];
    it.hour     = h[4:0];
    it.minute   = mi[5:0];
    it.second   = s[5:0];
    it.meridiem = mer;
    return it;
  endfunction

  // Called at a rising edge. Optional sender gaps, then hold start high until
  // the edge that takes the beat. start is left high for a following beat.
  task automatic send_beat(input cdte_in_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    data_i <= it;
    do @(posedge clk_i); while (busy);
    beats_sent++;
  endtask

  // Stop sending and wait until every pending result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (epoch_due.size() != 0);
  endtask

  // Mostly well-formed dates; some with exactly one field just out of range,
  // some with every field fully random.
  function automatic cdte_in_t random_datetime();
    cdte_in_t    it;
    int unsigned y, mo, len, kind;
    mer_e        mer;
    y   = $urandom_range(YearMax, YearMin);
    mo  = $urandom_range(12, 1);
    len = greg_month_days(y, mo);
    mer = mer_e'($urandom_range(2));
    it  = pack_dt(y, mo, $urandom_range(len, 1),
                  (mer == MER_NONE) ? $urandom_range(23) : $urandom_range(12, 1),
                  $urandom_range(59), $urandom_range(59), mer);
    kind = $urandom_range(99);
    if (kind >= 70 && kind < 88) begin
      case ($urandom_range(6))
        0: it.year   = $urandom_range(1) ? 14'd1999 + 14'($urandom_range(1) * 101)
                                         : 14'($urandom_range(16383));
        1: it.month  = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
        2: it.day    = (len == 31 || $urandom_range(1)) ? 5'd0
                                                        : 5'($urandom_range(31, len + 1));
        3: it.hour   = (mer == MER_NONE) ? 5'($urandom_range(31, 24))
                     : ($urandom_range(1) ? 5'd0 : 5'($urandom_range(31, 13)));
        4: it.minute = 6'($urandom_range(63, 60));
        5: it.second = 6'($urandom_range(63, 60));
        default: it.meridiem = MER_BAD;
      endcase
    end else if (kind >= 88) begin
      it = pack_dt($urandom_range(16383), $urandom_range(15), $urandom_range(31),
                   $urandom_range(31), $urandom_range(63), $urandom_range(63),
                   mer_e'($urandom_range(3)));
    end
    return it;
  endfunction

  task automatic run_random(input int unsigned n);
    repeat (n) send_beat(random_datetime());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Range edges of every field, leap-day rules, all-ones inputs.
  task automatic test_field_extremes();
    sender_idle_pct = 0;
    send_beat(pack_dt(2000, 1, 1, 0, 0, 0, MER_NONE));       // first valid second
    send_beat(pack_dt(2099, 12, 31, 23, 59, 59, MER_NONE));  // last valid second
    send_beat(pack_dt(1999, 12, 31, 23, 59, 59, MER_NONE));  // year just below
    send_beat(pack_dt(2100, 1, 1, 0, 0, 0, MER_NONE));       // year just above
    send_beat(pack_dt(0, 0, 0, 0, 0, 0, MER_NONE));          // all zero
    send_beat(pack_dt(16383, 15, 31, 31, 63, 63, MER_BAD));  // all ones
    send_beat(pack_dt(2050, 0, 10, 10, 10, 10, MER_NONE));   // month zero
    send_beat(pack_dt(2050, 13, 10, 10, 10, 10, MER_NONE));  // month past December
    send_beat(pack_dt(2050, 6, 0, 10, 10, 10, MER_NONE));    // day zero
    send_beat(pack_dt(2050, 4, 31, 10, 10, 10, MER_NONE));   // day past a 30-day month
    send_beat(pack_dt(2050, 1, 31, 10, 10, 10, MER_NONE));   // day 31 in January
    send_beat(pack_dt(2024, 2, 29, 12, 0, 0, MER_NONE));     // leap day, ordinary leap year
    send_beat(pack_dt(2023, 2, 29, 12, 0, 0, MER_NONE));     // no leap day
    send_beat(pack_dt(2000, 2, 29, 12, 0, 0, MER_NONE));     // century leap year
    send_beat(pack_dt(2000, 3, 1, 0, 0, 0, MER_NONE));       // day after it
    send_beat(pack_dt(2050, 6, 15, 24, 0, 0, MER_NONE));     // hour 24, 24h form
    send_beat(pack_dt(2050, 6, 15, 10, 60, 0, MER_NONE));    // minute 60
    send_beat(pack_dt(2050, 6, 15, 10, 0, 60, MER_NONE));    // second 60
  endtask

  // Twelve AM is midnight, twelve PM stays noon, other PM hours add twelve.
  task automatic test_meridiem_forms();
    sender_idle_pct = 0;
    send_beat(pack_dt(2038, 1, 19, 12, 14, 7, MER_AM));
    send_beat(pack_dt(2038, 1, 19, 12, 14, 7, MER_PM));
    send_beat(pack_dt(2038, 1, 19, 1, 0, 0, MER_PM));
    send_beat(pack_dt(2038, 1, 19, 11, 59, 59, MER_PM));
    send_beat(pack_dt(2038, 1, 19, 1, 0, 0, MER_AM));
    send_beat(pack_dt(2038, 1, 19, 0, 0, 0, MER_AM));        // hour 0 is not a 12h hour
    send_beat(pack_dt(2038, 1, 19, 13, 0, 0, MER_PM));       // 13 with a marker
    send_beat(pack_dt(2038, 1, 19, 5, 0, 0, MER_BAD));       // unknown marker
    wait_drained();
  endtask

  task automatic test_random_burst();
    sender_idle_pct = 0;
    run_random(110);
    wait_drained();
  endtask

  task automatic test_random_sparse();
    sender_idle_pct = 83;
    run_random(90);
    wait_drained();
  endtask

  task automatic test_random_mixed();
    sender_idle_pct = 29;
    run_random(110);
  endtask

  // Pipeline runs completely empty mid-stream, then traffic resumes.
  task automatic test_hold_until_drained();
    sender_idle_pct = 0;
    run_random(20);
    wait_drained();
    run_random(30);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    data_i          = '0;
    sender_idle_pct = 0;
    beats_sent      = 0;
    results_seen    = 0;
    valid_seen      = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_meridiem_forms();
    test_random_burst();
    test_random_sparse();
    test_random_mixed();
    test_hold_until_drained();

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d beats: field extremes, leap days, AM/PM forms, random traffic",
             beats_sent);
    $display("results checked %0d (%0d valid), mismatches %0d",
             results_seen, valid_seen, mismatches);
    if (mismatches == 0 && epoch_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cdte_pkg.sv
hw/rtl/cdte_front.sv
hw/rtl/cdte_queue.sv
hw/rtl/cdte_back.sv
hw/rtl/civil_datetime_to_epoch_top.sv
bench/tb.sv
